// ===== rtl/core/b2d_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII formatter.
// No dependencies; imported by every module of the block.
package b2d_pkg;

	localparam int unsigned VALUE_BITS      = 32;
	localparam int unsigned DEF_VALUE_WIDTH = 32;
	localparam int unsigned QUEUE_DEPTH     = 2;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_CONV,
		FS_DONE
	} front_state_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_SIGN,
		BS_DIGIT
	} back_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	// decimal digits needed for the largest w-bit unsigned number
	function automatic int unsigned dec_digits(input int unsigned w);
		return (w * 301) / 1000 + 1;
	endfunction

endpackage

// ===== rtl/core/binary_to_decimal_ascii_top.sv =====
// Binary word to decimal ASCII text, one character per strobe.
// The front end takes a new number only once the last one has been queued; throughput
// is set by the one-bit-per-cycle shift-and-add-3 converter in the front end.
// The first character strobes after conversion, the push into the queue and the pop;
// the rest follow on consecutive cycles, overlapped with the next conversion.
// Reset clears all control state and empties the queue; characters are never held.
module binary_to_decimal_ascii_top #(
	parameter int unsigned VALUE_WIDTH = b2d_pkg::DEF_VALUE_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [b2d_pkg::VALUE_BITS-1:0] value,
	input  logic                           kind,
	output logic                           strobe,
	output logic [7:0]                     character,
	output logic                           last
);
	import b2d_pkg::*;

	localparam int unsigned ENTRY_W = dec_digits(VALUE_WIDTH) * 4 + 1;

	fifo_status_t         fifo_st;
	logic                 push, pop;
	logic [ENTRY_W-1:0]   wr_entry, rd_entry;

	b2d_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.value   (value),
		.kind    (kind),
		.busy    (busy),
		.push    (push),
		.entry   (wr_entry),
		.fifo_st (fifo_st)
	);

	b2d_fifo #(.DATA_W(ENTRY_W)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pop     (pop),
		.wr_data (wr_entry),
		.rd_data (rd_entry),
		.status  (fifo_st)
	);

	b2d_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_st   (fifo_st),
		.entry     (rd_entry),
		.pop       (pop),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("front end did not go busy after a transfer");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && fifo_st.full))
		else $error("queue written while full");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && character == CHAR_MINUS |-> !last)
		else $error("sign issued as final character");

	a_text_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside the text of a number");

endmodule

// ===== rtl/core/b2d_front.sv =====
// Front end: takes a word, works out sign and magnitude, then converts the
// magnitude to BCD by shift-and-add-3, one bit per cycle. Uses b2d_pkg.
module b2d_front #(
	parameter int unsigned VALUE_WIDTH = b2d_pkg::DEF_VALUE_WIDTH
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           start,
	input  logic [b2d_pkg::VALUE_BITS-1:0]                 value,
	input  logic                                           kind,
	output logic                                           busy,
	output logic                                           push,
	output logic [b2d_pkg::dec_digits(VALUE_WIDTH)*4:0]    entry,
	input  b2d_pkg::fifo_status_t                          fifo_st
);
	import b2d_pkg::*;

	localparam int unsigned NDIG  = dec_digits(VALUE_WIDTH);
	localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

	front_state_t            state_q, state_d;
	logic [VALUE_WIDTH-1:0]  word, mag, shreg_q;
	logic [NDIG*4-1:0]       bcd_q, bcd_adj;
	logic [CNT_W-1:0]        cnt_q;
	logic                    neg, neg_q, accept, cnt_end;

	generate
		if (VALUE_WIDTH <= VALUE_BITS) begin : g_narrow
			assign word = value[VALUE_WIDTH-1:0];
		end else begin : g_wide
			assign word = {{(VALUE_WIDTH - VALUE_BITS){1'b0}}, value};
		end
	endgenerate

	// most negative word negates to itself, which read unsigned is its magnitude
	assign neg     = ~kind & word[VALUE_WIDTH-1];
	assign mag     = neg ? (~word + VALUE_WIDTH'(1)) : word;
	assign accept  = start && (state_q == FS_IDLE);
	assign cnt_end = (cnt_q == CNT_W'(VALUE_WIDTH - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_IDLE: begin
				if (start) state_d = FS_CONV;
			end
			FS_CONV: begin
				if (cnt_end) state_d = FS_DONE;
			end
			FS_DONE: begin
				if (!fifo_st.full) state_d = FS_IDLE;
			end
			default: state_d = FS_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b1;
		push = 1'b0;
		case (state_q)
			FS_IDLE: busy = 1'b0;
			FS_CONV: busy = 1'b1;
			FS_DONE: push = !fifo_st.full;
			default: busy = 1'b1;
		endcase
	end

	// add 3 to every digit of 5 or more ahead of the shift
	always_comb begin
		logic [3:0] d;
		for (int i = 0; i < NDIG; i++) begin
			d = bcd_q[i*4 +: 4];
			bcd_adj[i*4 +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
		end
	end

	assign entry = {neg_q, bcd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) cnt_q <= '0;
			else if (state_q == FS_CONV) cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			shreg_q <= mag;
			bcd_q   <= '0;
			neg_q   <= neg;
		end else if (state_q == FS_CONV) begin
			bcd_q   <= {bcd_adj[NDIG*4-2:0], shreg_q[VALUE_WIDTH-1]};
			shreg_q <= shreg_q << 1;
		end
	end

endmodule

// ===== rtl/core/b2d_fifo.sv =====
// Short queue of converted numbers between front and back ends.
// Uses b2d_pkg for depth and status type.
module b2d_fifo #(
	parameter int unsigned DATA_W = 41
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  pop,
	input  logic [DATA_W-1:0]     wr_data,
	output logic [DATA_W-1:0]     rd_data,
	output b2d_pkg::fifo_status_t status
);
	import b2d_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;

	assign status.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign rd_data      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop)  rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (push && !pop)      cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_data;
	end

endmodule

// ===== rtl/core/b2d_back.sv =====
// Back end: pops a converted number and issues its characters, sign first,
// leading zeros skipped, one per cycle. Uses b2d_pkg.
module b2d_back #(
	parameter int unsigned VALUE_WIDTH = b2d_pkg::DEF_VALUE_WIDTH
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  b2d_pkg::fifo_status_t                       fifo_st,
	input  logic [b2d_pkg::dec_digits(VALUE_WIDTH)*4:0] entry,
	output logic                                        pop,
	output logic                                        strobe,
	output logic [7:0]                                  character,
	output logic                                        last
);
	import b2d_pkg::*;

	localparam int unsigned NDIG  = dec_digits(VALUE_WIDTH);
	localparam int unsigned IDX_W = $clog2(NDIG);

	back_state_t        state_q, state_d;
	logic [IDX_W-1:0]   idx_q, msd;
	logic [NDIG*4-1:0]  bcd_q;
	logic [3:0]         digit;
	logic               take;

	assign take  = (state_q == BS_IDLE) && !fifo_st.empty;
	assign digit = bcd_q[idx_q*4 +: 4];

	// highest nonzero digit; zero itself leaves index 0
	always_comb begin
		msd = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (entry[i*4 +: 4] != 4'd0) msd = IDX_W'(i);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: begin
				if (!fifo_st.empty) state_d = entry[NDIG*4] ? BS_SIGN : BS_DIGIT;
			end
			BS_SIGN:  state_d = BS_DIGIT;
			BS_DIGIT: begin
				if (idx_q == '0) state_d = BS_IDLE;
			end
			default: state_d = BS_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		strobe    = 1'b0;
		character = CHAR_ZERO;
		last      = 1'b0;
		case (state_q)
			BS_IDLE: pop = !fifo_st.empty;
			BS_SIGN: begin
				strobe    = 1'b1;
				character = CHAR_MINUS;
			end
			BS_DIGIT: begin
				strobe    = 1'b1;
				character = CHAR_ZERO + {4'b0000, digit};
				last      = (idx_q == '0);
			end
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (take) idx_q <= msd;
			else if (state_q == BS_DIGIT && idx_q != '0) idx_q <= idx_q - IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) bcd_q <= entry[NDIG*4-1:0];
	end

endmodule

// ===== test/binary_to_decimal_ascii_top_tb.sv =====
// Testbench for binary_to_decimal_ascii_top: drives words through the start/busy handshake,
// predicts the decimal text of each one and checks every strobed character in order.
// Depends on b2d_pkg and the RTL of the block only.
module binary_to_decimal_ascii_top_tb;
	import b2d_pkg::*;

	localparam int unsigned WIDTH       = DEF_VALUE_WIDTH;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          DRAIN_WAIT  = WIDTH + 16;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} text_char_t;

	class decimal_text_scoreboard;
		text_char_t expected_chars[$];
		int         errors;
		int         numbers;
		int         negatives;
		int         chars_seen;

		function new();
			errors     = 0;
			numbers    = 0;
			negatives  = 0;
			chars_seen = 0;
		endfunction

		task report(input string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		// decimal text of one transfer, pushed in reading order
		function void note_number(input logic [VALUE_BITS-1:0] raw, input logic as_unsigned);
			logic [63:0] mask;
			logic [63:0] mag;
			logic        neg;
			logic [7:0]  text[$];
			text_char_t  tc;
			mask = (WIDTH >= 64) ? '1 : ((64'd1 << WIDTH) - 64'd1);
			mag  = {32'd0, raw} & mask;
			neg  = 1'b0;
			if (!as_unsigned && mag[WIDTH-1]) begin
				neg = 1'b1;
				mag = (~mag + 64'd1) & mask;
				if (mag == 64'd0)
					mag = 64'd1 << (WIDTH - 1);
			end
			do begin
				text.push_front(CHAR_ZERO + 8'(mag % 64'd10));
				mag = mag / 64'd10;
			end while (mag != 64'd0);
			if (neg) begin
				text.push_front(CHAR_MINUS);
				negatives++;
			end
			foreach (text[i]) begin
				tc.ch  = text[i];
				tc.fin = (i == text.size() - 1);
				expected_chars.push_back(tc);
			end
			numbers++;
		endfunction

		task check_char(input logic [7:0] ch, input logic fin);
			text_char_t want;
			chars_seen++;
			if (expected_chars.size() == 0) begin
				report($sformatf("character %h strobed with nothing outstanding", ch));
			end else begin
				want = expected_chars.pop_front();
				if (ch !== want.ch)
					report($sformatf("character %h, expected %h", ch, want.ch));
				if (fin !== want.fin)
					report($sformatf("last %b on character %h, expected %b", fin, ch, want.fin));
			end
		endtask
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic [VALUE_BITS-1:0] value     = '0;
	logic                  kind      = 1'b0;
	logic                  busy;
	logic                  strobe;
	logic [7:0]            character;
	logic                  last;

	decimal_text_scoreboard sb = new();
	int                     cycles  = 0;
	bit                     no_idle = 1'b0;

	binary_to_decimal_ascii_top #(.VALUE_WIDTH(WIDTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.kind(kind),
		.strobe(strobe),
		.character(character),
		.last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL binary_to_decimal_ascii_top");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_char(character, last);
	end

	// holds start until the transfer is taken, then records it
	task automatic send_number(input logic [VALUE_BITS-1:0] v, input logic k);
		start <= 1'b1;
		value <= v;
		kind  <= k;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_number(v, k);
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// start is only dropped when there is something left to wait for
	task automatic wait_drained();
		if (sb.expected_chars.size() != 0) begin
			start <= 1'b0;
			while (sb.expected_chars.size() != 0) @(posedge clk);
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic [VALUE_BITS-1:0] pick_value();
		logic [VALUE_BITS-1:0] p;
		int                    n;
		p = 1;
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 20);
			1: return 32'hFFFF_FFFF - $urandom_range(0, 20);
			2: begin
				n = $urandom_range(0, 9);
				repeat (n) p = p * 10;
				return p + $urandom_range(0, 2) - 1;
			end
			3: begin
				n = $urandom_range(0, 9);
				repeat (n) p = p * 10;
				return -(p + $urandom_range(0, 2) - 1);
			end
			4: return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
			                               : 32'h7FFF_FFFF - $urandom_range(0, 3);
			5: return $urandom() >> $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	initial begin
		logic [VALUE_BITS-1:0] corner[$];

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero, all ones, sign boundary, decade boundaries, largest lengths
		corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
		           32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999_999_999,
		           32'd1_000_000_000, -32'sd10, -32'sd9, -32'sd1_000_000_000};
		foreach (corner[i]) begin
			send_number(corner[i], 1'b0);
			send_number(corner[i], 1'b1);
			if (i > 9)
				idle_for(pick_gap());
		end

		// first ten corners back-to-back, random gaps after; then let it all drain before the random part
		wait_drained();

		for (int i = 0; i < 400; i++) begin
			if (i % 40 == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			if (i == 200)
				wait_drained();
			send_number(pick_value(), $urandom_range(0, 1));
			idle_for(pick_gap());
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.expected_chars.size() != 0)
			sb.report($sformatf("%0d characters never strobed", sb.expected_chars.size()));

		$display("Formatted %0d words (%0d read as negative), %0d characters checked.",
		         sb.numbers, sb.negatives, sb.chars_seen);
		if (sb.errors == 0)
			$display("PASS binary_to_decimal_ascii_top");
		else
			$display("FAIL binary_to_decimal_ascii_top");
		$finish;
	end

endmodule
